// ===== hw/rtl/ncttu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncttu_pkg
// Shared types, codes and helpers of the nearest-centroid track table.
// ----------------------------------------------------------------------------
package ncttu_pkg;

  localparam int CoordW  = 11;
  localparam int DistW   = 23;
  localparam int RectW   = 44;
  localparam int MaxList = 16;

  // Operation applied to every cell of a table row
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_LOAD_POS,
    CELL_LOAD_ALL,
    CELL_CLR_FLAG
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     sel;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_CPASS,
    ST_TPASS,
    ST_LIST,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    FUNC_START    = 2'd0,
    FUNC_CENTROID = 2'd1,
    FUNC_END      = 2'd2,
    FUNC_RSVD     = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    STAT_ACK       = 3'd0,
    STAT_TRACK     = 3'd1,
    STAT_CAND      = 3'd2,
    STAT_NEW       = 3'd3,
    STAT_FULL      = 3'd4,
    STAT_LIST      = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CFG_BEGIN_AREA = 3'd0,
    CFG_STOP_AREA  = 3'd1,
    CFG_LOST_LIMIT = 3'd2,
    CFG_GATE       = 3'd3,
    CFG_NOISE      = 3'd4
  } cfg_idx_e;

  // Point inside rectangle packed as x,y,w,h (x highest)
  function automatic logic in_rect(logic [RectW-1:0] rect, logic [CoordW-1:0] px,
                                   logic [CoordW-1:0] py);
    logic [CoordW:0] rx, ry, rw, rh;
    rx = {1'b0, rect[43:33]};
    ry = {1'b0, rect[32:22]};
    rw = {1'b0, rect[21:11]};
    rh = {1'b0, rect[10:0]};
    return (rx <= {1'b0, px}) && ({1'b0, px} < rx + rw) &&
           (ry <= {1'b0, py}) && ({1'b0, py} < ry + rh);
  endfunction

  // Squared Euclidean distance
  function automatic logic [DistW-1:0] dist_sq(logic [CoordW-1:0] ax, logic [CoordW-1:0] ay,
                                               logic [CoordW-1:0] bx, logic [CoordW-1:0] by);
    logic [CoordW-1:0]   dx, dy;
    logic [2*CoordW-1:0] sx, sy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    sx = dx * dx;
    sy = dy * dy;
    return {1'b0, sx} + {1'b0, sy};
  endfunction

endpackage

// ===== hw/rtl/ncttu_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncttu_cell
// One table entry: center, seen and missed counts, seen-this-frame flag.
// ----------------------------------------------------------------------------
module ncttu_cell
  import ncttu_pkg::*;
#(
  parameter int CountBits = 16
) (
  input  logic                 clk_i,
  input  cell_ctrl_t           ctrl_i,
  input  logic [CoordW-1:0]    nbr_x_i,
  input  logic [CoordW-1:0]    nbr_y_i,
  input  logic [CountBits-1:0] nbr_seen_i,
  input  logic [CountBits-1:0] nbr_missed_i,
  input  logic                 nbr_flag_i,
  input  logic [CoordW-1:0]    wr_x_i,
  input  logic [CoordW-1:0]    wr_y_i,
  input  logic [CountBits-1:0] wr_seen_i,
  input  logic [CountBits-1:0] wr_missed_i,
  input  logic                 wr_flag_i,
  output logic [CoordW-1:0]    x_o,
  output logic [CoordW-1:0]    y_o,
  output logic [CountBits-1:0] seen_o,
  output logic [CountBits-1:0] missed_o,
  output logic                 flag_o
);

  logic [CoordW-1:0]    x_q, y_q;
  logic [CountBits-1:0] seen_q, missed_q;
  logic                 flag_q;

  // Take neighbor, load a write, or clear the flag
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      CELL_SHIFT: begin
        if (ctrl_i.sel) begin
          x_q      <= wr_x_i;
          y_q      <= wr_y_i;
          seen_q   <= wr_seen_i;
          missed_q <= wr_missed_i;
          flag_q   <= wr_flag_i;
        end else begin
          x_q      <= nbr_x_i;
          y_q      <= nbr_y_i;
          seen_q   <= nbr_seen_i;
          missed_q <= nbr_missed_i;
          flag_q   <= nbr_flag_i;
        end
      end
      CELL_LOAD_POS: begin
        if (ctrl_i.sel) begin
          x_q    <= wr_x_i;
          y_q    <= wr_y_i;
          flag_q <= wr_flag_i;
        end
      end
      CELL_LOAD_ALL: begin
        if (ctrl_i.sel) begin
          x_q      <= wr_x_i;
          y_q      <= wr_y_i;
          seen_q   <= wr_seen_i;
          missed_q <= wr_missed_i;
          flag_q   <= wr_flag_i;
        end
      end
      CELL_CLR_FLAG: flag_q <= 1'b0;
      default: ;
    endcase
  end

  assign x_o      = x_q;
  assign y_o      = y_q;
  assign seen_o   = seen_q;
  assign missed_o = missed_q;
  assign flag_o   = flag_q;

endmodule

// ===== hw/rtl/ncttu_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncttu_table
// Row of entry cells; each shifts toward the head, one write slot per cycle.
// ----------------------------------------------------------------------------
module ncttu_table
  import ncttu_pkg::*;
#(
  parameter int Slots     = 16,
  parameter int CountBits = 16,
  localparam int IdxW     = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  logic                 clk_i,
  input  cell_op_e             op_i,
  input  logic                 wr_en_i,
  input  logic [IdxW-1:0]      idx_i,
  input  logic [CoordW-1:0]    wr_x_i,
  input  logic [CoordW-1:0]    wr_y_i,
  input  logic [CountBits-1:0] wr_seen_i,
  input  logic [CountBits-1:0] wr_missed_i,
  input  logic                 wr_flag_i,
  output logic [CoordW-1:0]    head_x_o,
  output logic [CoordW-1:0]    head_y_o,
  output logic [CountBits-1:0] head_seen_o,
  output logic [CountBits-1:0] head_missed_o,
  output logic                 head_flag_o
);

  logic [CoordW-1:0]    x_w      [Slots];
  logic [CoordW-1:0]    y_w      [Slots];
  logic [CountBits-1:0] seen_w   [Slots];
  logic [CountBits-1:0] missed_w [Slots];
  logic                 flag_w   [Slots];

  for (genvar i = 0; i < Slots; i++) begin : g_cell
    localparam int Nb = (i < Slots - 1) ? i + 1 : i;
    cell_ctrl_t ctrl;

    // Select the one cell addressed by the write
    assign ctrl = {op_i, wr_en_i && (idx_i == IdxW'(i))};

    ncttu_cell #(
      .CountBits(CountBits)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .nbr_x_i     (x_w[Nb]),
      .nbr_y_i     (y_w[Nb]),
      .nbr_seen_i  (seen_w[Nb]),
      .nbr_missed_i(missed_w[Nb]),
      .nbr_flag_i  (flag_w[Nb]),
      .wr_x_i      (wr_x_i),
      .wr_y_i      (wr_y_i),
      .wr_seen_i   (wr_seen_i),
      .wr_missed_i (wr_missed_i),
      .wr_flag_i   (wr_flag_i),
      .x_o         (x_w[i]),
      .y_o         (y_w[i]),
      .seen_o      (seen_w[i]),
      .missed_o    (missed_w[i]),
      .flag_o      (flag_w[i])
    );
  end

  assign head_x_o      = x_w[0];
  assign head_y_o      = y_w[0];
  assign head_seen_o   = seen_w[0];
  assign head_missed_o = missed_w[0];
  assign head_flag_o   = flag_w[0];

endmodule

// ===== hw/rtl/nearest_centroid_track_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_track_table_unit
// Candidate and track tables with nearest-centroid association per frame.
// ----------------------------------------------------------------------------
// Each table is a row of cells that shifts toward its head; all work is done
// on the head entry while the row rotates, so item latency follows the table
// fill. A centroid rotates both rows once to find the nearest gated entries,
// then passes through an update state and a response state. Frame end runs a
// candidate pass, a track pass, then a listing rotation that stalls while the
// output register is held, giving one result per tracked entry, at most 16,
// or one empty result when no track is left.
module nearest_centroid_track_table_unit
  import ncttu_pkg::*;
#(
  parameter int CAND_SLOTS  = 16,
  parameter int TRACK_SLOTS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [43:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [10:0] pos_x_i,
  input  logic [10:0] pos_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        has_entry_o,
  output logic [10:0] out_x_o,
  output logic [10:0] out_y_o,
  output logic        last_o
);

  localparam int CCntW    = $clog2(CAND_SLOTS + 1);
  localparam int TCntW    = $clog2(TRACK_SLOTS + 1);
  localparam int CIdxW    = (CAND_SLOTS > 1) ? $clog2(CAND_SLOTS) : 1;
  localparam int TIdxW    = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int MaxSlots = (CAND_SLOTS > TRACK_SLOTS) ? CAND_SLOTS : TRACK_SLOTS;
  localparam int StepW    = $clog2(MaxSlots + 1);
  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

  // Configuration registers
  logic [RectW-1:0] begin_area_q, stop_area_q;
  logic [7:0]       lost_limit_q, noise_ratio_q;
  logic [DistW-1:0] gate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_area_q  <= 44'd2112700277082;
      stop_area_q   <= 44'd1584551616944;
      lost_limit_q  <= 8'd10;
      gate_q        <= 23'd2500;
      noise_ratio_q <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BEGIN_AREA: begin_area_q  <= cfg_data_i;
        CFG_STOP_AREA:  stop_area_q   <= cfg_data_i;
        CFG_LOST_LIMIT: lost_limit_q  <= cfg_data_i[7:0];
        CFG_GATE:       gate_q        <= cfg_data_i[DistW-1:0];
        CFG_NOISE:      noise_ratio_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Control and work registers
  state_e            state_q, state_d;
  logic [CCntW-1:0]  ccnt_q;
  logic [TCntW-1:0]  tcnt_q;
  logic [StepW-1:0]  step_q, pass_n_q;
  logic [CoordW-1:0] px_q, py_q;
  logic              c_found_q, t_found_q;
  logic [DistW-1:0]  c_best_q, t_best_q;
  logic [CIdxW-1:0]  c_idx_q;
  logic [TIdxW-1:0]  t_idx_q;
  status_e           resp_q;
  logic              out_valid_q;
  logic [2:0]        out_status_q;
  logic              out_has_q, out_last_q;
  logic [CoordW-1:0] out_x_q, out_y_q;

  // Table heads
  logic [CoordW-1:0]     ch_x, ch_y, th_x, th_y;
  logic [COUNT_BITS-1:0] ch_seen, ch_missed, th_seen, th_missed;
  logic                  ch_flag, th_flag;

  // Table controls
  cell_op_e              c_op, t_op;
  logic                  c_wen, t_wen;
  logic [CIdxW-1:0]      c_idx;
  logic [TIdxW-1:0]      t_idx;
  logic [CoordW-1:0]     c_wx, c_wy, t_wx, t_wy;
  logic [COUNT_BITS-1:0] c_ws, c_wm, t_ws, t_wm;
  logic                  c_wf, t_wf;

  logic in_xfer, out_free, out_load;
  logic [2:0]        ld_status;
  logic              ld_has, ld_last;
  logic [CoordW-1:0] ld_x, ld_y;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Search terms on the heads
  logic [DistW-1:0] cd, td;
  logic [StepW-1:0] search_n;
  logic             c_act, t_act, c_hit, t_hit, search_done;

  assign cd       = dist_sq(ch_x, ch_y, px_q, py_q);
  assign td       = dist_sq(th_x, th_y, px_q, py_q);
  assign search_n = (StepW'(ccnt_q) > StepW'(tcnt_q)) ? StepW'(ccnt_q) : StepW'(tcnt_q);
  assign c_act    = step_q < StepW'(ccnt_q);
  assign t_act    = step_q < StepW'(tcnt_q);
  assign c_hit    = c_act && (cd < gate_q) && (!c_found_q || cd < c_best_q);
  assign t_hit    = t_act && (td < gate_q) && (!t_found_q || td < t_best_q);
  assign search_done = ({1'b0, step_q} + 1'b1) >= {1'b0, search_n};

  // Association decision
  logic pick_track, pick_cand, cand_room;
  assign pick_track = t_found_q && !(c_found_q && ({1'b0, t_best_q} > {c_best_q, 1'b0}));
  assign pick_cand  = !pick_track && c_found_q;
  assign cand_room  = ccnt_q < CCntW'(CAND_SLOTS);

  // Frame-end count updates on both heads
  logic [COUNT_BITS-1:0] cu_seen, cu_missed, tu_seen, tu_missed;
  logic                  pass_act, promote, keep, noise, lost;
  logic [COUNT_BITS+7:0] noise_lim;

  always_comb begin
    cu_seen   = ch_seen;
    cu_missed = ch_missed;
    if (ch_flag) begin
      cu_missed = '0;
      if (ch_seen != CntMax) cu_seen = ch_seen + 1'b1;
    end else if (ch_missed != CntMax) begin
      cu_missed = ch_missed + 1'b1;
    end
    tu_seen   = th_seen;
    tu_missed = th_missed;
    if (th_flag) begin
      tu_missed = '0;
      if (th_seen != CntMax) tu_seen = th_seen + 1'b1;
    end else if (th_missed != CntMax) begin
      tu_missed = th_missed + 1'b1;
    end
  end

  assign pass_act  = step_q < pass_n_q;
  assign promote   = in_rect(begin_area_q, ch_x, ch_y) && (tcnt_q < TCntW'(TRACK_SLOTS));
  assign noise_lim = noise_ratio_q * tu_missed;
  assign noise     = (tu_missed != '0) && ({8'd0, tu_seen} < noise_lim);
  assign lost      = (tu_missed > lost_limit_q) && !in_rect(stop_area_q, th_x, th_y);
  assign keep      = !(noise || lost);

  // Listing step
  logic list_emit, list_step, list_last;
  assign list_emit = pass_act && (step_q < MaxList) && out_free;
  assign list_step = pass_act && ((step_q >= MaxList) || out_free);
  assign list_last = (({1'b0, step_q} + 1'b1) == {1'b0, pass_n_q}) ||
                     (({1'b0, step_q} + 1'b1) == (StepW + 1)'(MaxList));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          priority case (func_i)
            FUNC_CENTROID: state_d = ST_SEARCH;
            FUNC_END:      state_d = ST_CPASS;
            default:       state_d = ST_RESP;
          endcase
        end
      end
      ST_SEARCH: if (search_done) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_RESP;
      ST_CPASS:  if (!pass_act) state_d = ST_TPASS;
      ST_TPASS:  if (!pass_act) state_d = (tcnt_q == '0) ? ST_RESP : ST_LIST;
      ST_LIST:   if (!pass_act) state_d = ST_IDLE;
      ST_RESP:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Table operations and result loads
  always_comb begin
    c_op  = CELL_HOLD;
    t_op  = CELL_HOLD;
    c_wen = 1'b0;
    t_wen = 1'b0;
    c_idx = CIdxW'(ccnt_q - 1'b1);
    t_idx = TIdxW'(tcnt_q - 1'b1);
    c_wx  = ch_x;
    c_wy  = ch_y;
    c_ws  = ch_seen;
    c_wm  = ch_missed;
    c_wf  = ch_flag;
    t_wx  = th_x;
    t_wy  = th_y;
    t_ws  = th_seen;
    t_wm  = th_missed;
    t_wf  = th_flag;
    out_load  = 1'b0;
    ld_status = resp_q;
    ld_has    = 1'b0;
    ld_last   = 1'b1;
    ld_x      = '0;
    ld_y      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && func_i == FUNC_START) begin
          c_op = CELL_CLR_FLAG;
          t_op = CELL_CLR_FLAG;
        end
      end
      ST_SEARCH: begin
        // rotate each row once through its head
        if (c_act) begin
          c_op  = CELL_SHIFT;
          c_wen = 1'b1;
        end
        if (t_act) begin
          t_op  = CELL_SHIFT;
          t_wen = 1'b1;
        end
      end
      ST_UPDATE: begin
        c_wx = px_q;
        c_wy = py_q;
        c_wf = 1'b1;
        t_wx = px_q;
        t_wy = py_q;
        t_wf = 1'b1;
        if (pick_track) begin
          t_op  = CELL_LOAD_POS;
          t_wen = 1'b1;
          t_idx = t_idx_q;
        end else if (pick_cand) begin
          c_op  = CELL_LOAD_POS;
          c_wen = 1'b1;
          c_idx = c_idx_q;
        end else if (cand_room) begin
          c_op  = CELL_LOAD_ALL;
          c_wen = 1'b1;
          c_idx = CIdxW'(ccnt_q);
          c_ws  = '0;
          c_wm  = '0;
        end
      end
      ST_CPASS: begin
        if (pass_act) begin
          c_op  = CELL_SHIFT;
          c_wen = !promote;
          c_ws  = cu_seen;
          c_wm  = cu_missed;
          if (promote) begin
            t_op  = CELL_LOAD_ALL;
            t_wen = 1'b1;
            t_idx = TIdxW'(tcnt_q);
            t_wx  = ch_x;
            t_wy  = ch_y;
            t_ws  = cu_seen;
            t_wm  = cu_missed;
            t_wf  = ch_flag;
          end
        end
      end
      ST_TPASS: begin
        if (pass_act) begin
          t_op  = CELL_SHIFT;
          t_wen = keep;
          t_ws  = tu_seen;
          t_wm  = tu_missed;
        end
      end
      ST_LIST: begin
        if (list_step) begin
          t_op  = CELL_SHIFT;
          t_wen = 1'b1;
        end
        if (list_emit) begin
          out_load  = 1'b1;
          ld_status = STAT_LIST;
          ld_has    = 1'b1;
          ld_last   = list_last;
          ld_x      = th_x;
          ld_y      = th_y;
        end
      end
      ST_RESP: out_load = out_free;
      default: ;
    endcase
  end

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ccnt_q  <= '0;
      tcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_UPDATE && !pick_track && !pick_cand && cand_room) begin
        ccnt_q <= ccnt_q + 1'b1;
      end
      if (state_q == ST_CPASS && pass_act && promote) begin
        ccnt_q <= ccnt_q - 1'b1;
        tcnt_q <= tcnt_q + 1'b1;
      end
      if (state_q == ST_TPASS && pass_act && !keep) begin
        tcnt_q <= tcnt_q - 1'b1;
      end
    end
  end

  // Work registers: step count, search bests, pending response
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      pass_n_q  <= '0;
      c_found_q <= 1'b0;
      t_found_q <= 1'b0;
      resp_q    <= STAT_ACK;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          step_q    <= '0;
          pass_n_q  <= StepW'(ccnt_q);
          c_found_q <= 1'b0;
          t_found_q <= 1'b0;
          resp_q    <= STAT_ACK;
        end
        ST_SEARCH: begin
          step_q <= step_q + 1'b1;
          if (c_hit) c_found_q <= 1'b1;
          if (t_hit) t_found_q <= 1'b1;
        end
        ST_UPDATE: begin
          if (pick_track)     resp_q <= STAT_TRACK;
          else if (pick_cand) resp_q <= STAT_CAND;
          else if (cand_room) resp_q <= STAT_NEW;
          else                resp_q <= STAT_FULL;
        end
        ST_CPASS: begin
          if (pass_act) begin
            step_q <= step_q + 1'b1;
          end else begin
            step_q   <= '0;
            pass_n_q <= StepW'(tcnt_q);
          end
        end
        ST_TPASS: begin
          if (pass_act) begin
            step_q <= step_q + 1'b1;
          end else begin
            step_q   <= '0;
            pass_n_q <= StepW'(tcnt_q);
            resp_q   <= STAT_LIST;
          end
        end
        ST_LIST: if (list_step) step_q <= step_q + 1'b1;
        default: ;
      endcase
    end
  end

  // Payload of the search
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
    end
    if (state_q == ST_SEARCH && c_hit) begin
      c_best_q <= cd;
      c_idx_q  <= step_q[CIdxW-1:0];
    end
    if (state_q == ST_SEARCH && t_hit) begin
      t_best_q <= td;
      t_idx_q  <= step_q[TIdxW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= ld_status;
      out_has_q    <= ld_has;
      out_x_q      <= ld_x;
      out_y_q      <= ld_y;
      out_last_q   <= ld_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign has_entry_o = out_has_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign last_o      = out_last_q;

  // Table rows
  ncttu_table #(
    .Slots    (CAND_SLOTS),
    .CountBits(COUNT_BITS)
  ) u_cand (
    .clk_i        (clk_i),
    .op_i         (c_op),
    .wr_en_i      (c_wen),
    .idx_i        (c_idx),
    .wr_x_i       (c_wx),
    .wr_y_i       (c_wy),
    .wr_seen_i    (c_ws),
    .wr_missed_i  (c_wm),
    .wr_flag_i    (c_wf),
    .head_x_o     (ch_x),
    .head_y_o     (ch_y),
    .head_seen_o  (ch_seen),
    .head_missed_o(ch_missed),
    .head_flag_o  (ch_flag)
  );

  ncttu_table #(
    .Slots    (TRACK_SLOTS),
    .CountBits(COUNT_BITS)
  ) u_track (
    .clk_i        (clk_i),
    .op_i         (t_op),
    .wr_en_i      (t_wen),
    .idx_i        (t_idx),
    .wr_x_i       (t_wx),
    .wr_y_i       (t_wy),
    .wr_seen_i    (t_ws),
    .wr_missed_i  (t_wm),
    .wr_flag_i    (t_wf),
    .head_x_o     (th_x),
    .head_y_o     (th_y),
    .head_seen_o  (th_seen),
    .head_missed_o(th_missed),
    .head_flag_o  (th_flag)
  );

  // Checks
  a_ccnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ccnt_q <= CCntW'(CAND_SLOTS))
    else $error("candidate count beyond table size");

  a_tcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tcnt_q <= TCntW'(TRACK_SLOTS))
    else $error("track count beyond table size");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != ST_IDLE))
    else $error("input transfer left the unit idle");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result overwrote a pending transfer");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest-centroid track table unit: directed
// frames, then random frames of clustered centroids, most under random backpressure,
// checked against an in-bench model of both tables.
// ----------------------------------------------------------------------------
module testbench
  import ncttu_pkg::*;
();

  localparam int NCand  = 16;
  localparam int NTrack = 16;
  localparam logic [15:0] CountMax = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [10:0] px;
    logic [10:0] py;
  } frame_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        has;
    logic [10:0] x;
    logic [10:0] y;
    logic        last;
  } tbl_result_t;

  typedef struct {
    logic [10:0] x;
    logic [10:0] y;
    logic [15:0] seen;
    logic [15:0] missed;
    logic        flag;
  } obj_t;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [43:0] cfg_data_i;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  func_i;
  logic [10:0] pos_x_i, pos_y_i;
  logic        out_valid_o, out_ready_i;
  logic [2:0]  status_o;
  logic        has_entry_o, last_o;
  logic [10:0] out_x_o, out_y_o;

  nearest_centroid_track_table_unit u_top (.*);

  // Model state and configuration
  obj_t        cands[NCand];
  obj_t        tracks[NTrack];
  int          n_cand, n_track;
  logic [43:0] m_begin, m_stop;
  logic [7:0]  m_lost, m_noise;
  logic [22:0] m_gate;

  frame_cmd_t  cmd_q[$];
  tbl_result_t expected_q[$];
  int          errors, n_sent, n_results, n_cfg;
  logic        fast_mode;
  int          in_idle, out_idle;
  logic        in_ready_accepted;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("** nearest_centroid_track_table_unit: FAILED **");
    $finish;
  end

  function automatic logic inside_rect(logic [43:0] r, logic [10:0] px, logic [10:0] py);
    logic [11:0] rx, ry, rw, rh;
    rx = {1'b0, r[43:33]};
    ry = {1'b0, r[32:22]};
    rw = {1'b0, r[21:11]};
    rh = {1'b0, r[10:0]};
    return rx <= {1'b0, px} && {1'b0, px} < rx + rw && ry <= {1'b0, py} &&
           {1'b0, py} < ry + rh;
  endfunction

  function automatic logic [23:0] span_sq(obj_t e, logic [10:0] px, logic [10:0] py);
    logic [23:0] dx, dy;
    dx = e.x > px ? e.x - px : px - e.x;
    dy = e.y > py ? e.y - py : py - e.y;
    return dx * dx + dy * dy;
  endfunction

  function automatic obj_t age_entry(obj_t e);
    obj_t r;
    r = e;
    if (r.flag) begin
      r.missed = '0;
      if (r.seen != CountMax) r.seen++;
    end else if (r.missed != CountMax) begin
      r.missed++;
    end
    return r;
  endfunction

  task automatic push_result(status_e st, logic has, logic [10:0] x, logic [10:0] y,
                             logic last);
    tbl_result_t r;
    r.status = st;
    r.has = has;
    r.x = x;
    r.y = y;
    r.last = last;
    expected_q = {expected_q, r};
  endtask

  // Append one command to the pending list
  task automatic queue_cmd(frame_cmd_t c);
    cmd_q = {cmd_q, c};
  endtask

  // Compute the results of one command and advance the model tables
  task automatic predict_tables(frame_cmd_t c);
    int ti, ci, w, k;
    logic [23:0] dt, dc, d;
    obj_t e;
    logic noise, lost;
    ti = -1;
    ci = -1;
    dt = 0;
    dc = 0;
    case (c.func)
      FUNC_START: begin
        for (int i = 0; i < n_cand; i++) cands[i].flag = 1'b0;
        for (int i = 0; i < n_track; i++) tracks[i].flag = 1'b0;
        push_result(STAT_ACK, 1'b0, '0, '0, 1'b1);
      end
      FUNC_CENTROID: begin
        for (int i = 0; i < n_track; i++) begin
          d = span_sq(tracks[i], c.px, c.py);
          if (d < m_gate && (ti < 0 || d < dt)) begin
            dt = d;
            ti = i;
          end
        end
        for (int i = 0; i < n_cand; i++) begin
          d = span_sq(cands[i], c.px, c.py);
          if (d < m_gate && (ci < 0 || d < dc)) begin
            dc = d;
            ci = i;
          end
        end
        if (ti >= 0 && !(ci >= 0 && {1'b0, dt} > {dc, 1'b0})) begin
          tracks[ti].x = c.px;
          tracks[ti].y = c.py;
          tracks[ti].flag = 1'b1;
          push_result(STAT_TRACK, 1'b0, '0, '0, 1'b1);
        end else if (ci >= 0) begin
          cands[ci].x = c.px;
          cands[ci].y = c.py;
          cands[ci].flag = 1'b1;
          push_result(STAT_CAND, 1'b0, '0, '0, 1'b1);
        end else if (n_cand < NCand) begin
          cands[n_cand] = '{c.px, c.py, 16'd0, 16'd0, 1'b1};
          n_cand++;
          push_result(STAT_NEW, 1'b0, '0, '0, 1'b1);
        end else begin
          push_result(STAT_FULL, 1'b0, '0, '0, 1'b1);
        end
      end
      FUNC_END: begin
        w = 0;
        for (int i = 0; i < n_cand; i++) begin
          e = age_entry(cands[i]);
          if (inside_rect(m_begin, e.x, e.y) && n_track < NTrack) begin
            tracks[n_track] = e;
            n_track++;
          end else begin
            cands[w] = e;
            w++;
          end
        end
        n_cand = w;
        w = 0;
        for (int i = 0; i < n_track; i++) begin
          e = age_entry(tracks[i]);
          noise = e.missed != 0 && {8'd0, e.seen} < m_noise * e.missed;
          lost = e.missed > m_lost && !inside_rect(m_stop, e.x, e.y);
          if (!(noise || lost)) begin
            tracks[w] = e;
            w++;
          end
        end
        n_track = w;
        if (n_track == 0) push_result(STAT_LIST, 1'b0, '0, '0, 1'b1);
        k = 0;
        for (int i = 0; i < n_track && k < MaxList; i++) begin
          push_result(STAT_LIST, 1'b1, tracks[i].x, tracks[i].y,
                      (i + 1 == n_track) || (k + 1 == MaxList));
          k++;
        end
      end
      default: push_result(STAT_ACK, 1'b0, '0, '0, 1'b1);
    endcase
  endtask

  // Driver: present queued commands, idle in bursts
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_idle    <= 0;
      func_i     <= FUNC_START;
      pos_x_i    <= '0;
      pos_y_i    <= '0;
    end else if (!(in_valid_i && !in_ready_accepted)) begin
      if (in_idle > 0) begin
        in_valid_i <= 1'b0;
        in_idle    <= in_idle - 1;
      end else if (cmd_q.size() > 0 && (fast_mode || $urandom_range(0, 7) != 0)) begin
        in_valid_i <= 1'b1;
        func_i     <= cmd_q[0].func;
        pos_x_i    <= cmd_q[0].px;
        pos_y_i    <= cmd_q[0].py;
        predict_tables(cmd_q.pop_front());
      end else begin
        in_valid_i <= 1'b0;
        if (!fast_mode && $urandom_range(0, 9) == 0) in_idle <= $urandom_range(1, 15);
      end
    end
  end

  // Track whether the presented command was taken at the last rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ready_accepted <= 1'b0;
    end else begin
      in_ready_accepted <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) n_sent++;
    end
  end

  // Receiver stalls
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_idle    <= 0;
    end else if (fast_mode) begin
      out_ready_i <= 1'b1;
    end else if (out_idle > 0) begin
      out_ready_i <= 1'b0;
      out_idle    <= out_idle - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      out_idle    <= $urandom_range(1, 15);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    tbl_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("unexpected result status=%0d", status_o);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, status_o);
          errors++;
        end
        if (has_entry_o !== exp_r.has) begin
          $error("has_entry exp %0d got %0d", exp_r.has, has_entry_o);
          errors++;
        end
        if (out_x_o !== exp_r.x) begin
          $error("out_x exp %0d got %0d", exp_r.x, out_x_o);
          errors++;
        end
        if (out_y_o !== exp_r.y) begin
          $error("out_y exp %0d got %0d", exp_r.y, out_y_o);
          errors++;
        end
        if (last_o !== exp_r.last) begin
          $error("last exp %0d got %0d", exp_r.last, last_o);
          errors++;
        end
      end
    end
  end

  function automatic frame_cmd_t mk(func_e f, int x, int y);
    frame_cmd_t c;
    c.func = f;
    c.px = x[10:0];
    c.py = y[10:0];
    return c;
  endfunction

  // Let everything queued drain, then idle so any frame-end rotation can finish
  task automatic drain();
    while (cmd_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [43:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BEGIN_AREA: m_begin = val;
      CFG_STOP_AREA:  m_stop = val;
      CFG_LOST_LIMIT: m_lost = val[7:0];
      CFG_GATE:       m_gate = val[22:0];
      default:        m_noise = val[7:0];
    endcase
    n_cfg++;
  endtask

  // One random frame around a 4 by 4 grid of cluster centers, with stray random points
  task automatic rand_frame(int n, int cx, int cy, int spread);
    queue_cmd(mk(FUNC_START, $urandom, $urandom));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0)
        queue_cmd(mk(FUNC_CENTROID, $urandom_range(0, 2047), $urandom_range(0, 2047)));
      else
        queue_cmd(mk(FUNC_CENTROID,
                     (cx + $urandom_range(0, 3) * 300 + $urandom_range(0, spread)) % 2048,
                     (cy + $urandom_range(0, 3) * 300 + $urandom_range(0, spread)) % 2048));
    end
    if ($urandom_range(0, 20) == 0) queue_cmd(mk(FUNC_RSVD, 0, 0));
    queue_cmd(mk(FUNC_END, $urandom, $urandom));
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_BEGIN_AREA;
    cfg_data_i = '0;
    fast_mode = 1'b0;
    errors = 0;
    n_sent = 0;
    n_results = 0;
    n_cfg = 0;
    n_cand = 0;
    n_track = 0;
    m_begin = 44'd2112700277082;
    m_stop = 44'd1584551616944;
    m_lost = 8'd10;
    m_gate = 23'd2500;
    m_noise = 8'd5;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, unused code, promotion with default areas
    queue_cmd(mk(FUNC_END, 0, 0));
    queue_cmd(mk(FUNC_START, 0, 0));
    queue_cmd(mk(FUNC_CENTROID, 0, 0));
    queue_cmd(mk(FUNC_CENTROID, 2047, 2047));
    queue_cmd(mk(FUNC_CENTROID, 1, 1));
    queue_cmd(mk(FUNC_CENTROID, 1365, 682));
    queue_cmd(mk(FUNC_RSVD, 2047, 2047));
    queue_cmd(mk(FUNC_END, 2047, 2047));
    queue_cmd(mk(FUNC_END, 0, 0));
    drain();

    // Accept everything, then fill both tables and overflow the candidates
    write_reg(CFG_BEGIN_AREA, {11'd0, 11'd0, 11'd2047, 11'd2047});
    write_reg(CFG_STOP_AREA, '0);
    write_reg(CFG_NOISE, 8'd0);
    write_reg(CFG_LOST_LIMIT, 8'd255);
    write_reg(CFG_GATE, 23'd0);
    queue_cmd(mk(FUNC_START, 0, 0));
    for (int i = 0; i < 18; i++) queue_cmd(mk(FUNC_CENTROID, i * 100, 2047 - i * 100));
    queue_cmd(mk(FUNC_END, 0, 0));
    queue_cmd(mk(FUNC_START, 0, 0));
    for (int i = 0; i < 18; i++) queue_cmd(mk(FUNC_CENTROID, i * 7, i * 9));
    queue_cmd(mk(FUNC_END, 0, 0));
    drain();

    // Random frames across several settings, some with extreme limits
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_GATE, phase == 1 ? 23'h7FFFFF : $urandom_range(100, 40000));
      write_reg(CFG_NOISE, phase == 2 ? 8'd255 : $urandom_range(0, 6));
      write_reg(CFG_LOST_LIMIT, phase == 3 ? 8'd0 : $urandom_range(0, 4));
      write_reg(CFG_BEGIN_AREA, phase == 4 ? 44'hFFFFFFFFFFF :
                {11'($urandom_range(0, 800)), 11'($urandom_range(0, 800)),
                 11'($urandom_range(200, 2047)), 11'($urandom_range(200, 2047))});
      write_reg(CFG_STOP_AREA, {11'($urandom), 11'($urandom), 11'($urandom), 11'($urandom)});
      for (int f = 0; f < 4; f++) rand_frame($urandom_range(2, 8), $urandom_range(0, 1200),
                                              $urandom_range(0, 1200), 60);
      if (phase == 5) fast_mode = 1'b1;
      drain();
    end
    drain();

    $display("Covered %0d commands (%0d results), %0d register writes, directed table",
             n_sent, n_results, n_cfg);
    $display("overflow plus random clustered frames under backpressure.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** nearest_centroid_track_table_unit: PASSED **");
    end else begin
      $display("** nearest_centroid_track_table_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ncttu_pkg.sv
hw/rtl/ncttu_cell.sv
hw/rtl/ncttu_table.sv
hw/rtl/nearest_centroid_track_table_unit.sv
tb/testbench.sv
